// ----- rtl/core/rotation_matrix_to_quaternion_top_defines.svh -----
// Assertion macros for the rotation matrix to quaternion checker
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_DEFINES_SVH

// clocked check, disabled while in reset
`define RMQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rmq check failed");

// clocked check that also holds through reset
`define RMQ_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("rmq reset check failed");

`endif

// ----- rtl/core/rmq_pkg.sv -----
// Types, constants and helpers for the rotation matrix to quaternion block
`default_nettype none
package rmq_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 14;

  localparam int CAND_W = ((DATA_WIDTH > FRAC_BITS + 1) ? DATA_WIDTH : FRAC_BITS + 1) + 3;
  localparam int E_W    = CAND_W - 1;
  localparam int N_W    = E_W + FRAC_BITS - 2;
  localparam int ROOT_W = (N_W + 1) / 2;
  localparam int N_W2   = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int SUM_W  = DATA_WIDTH + 1;
  localparam int MAG_W  = SUM_W;
  localparam int QW     = DATA_WIDTH + 1;
  localparam int DIVD_W = MAG_W + FRAC_BITS - 2;
  localparam int CMP_W  = (QW > ROOT_W) ? QW : ROOT_W;
  localparam int LATENCY = 2 + ROOT_W + 1 + QW + 1;

  localparam logic [1:0] IDX_X = 2'd0;
  localparam logic [1:0] IDX_Y = 2'd1;
  localparam logic [1:0] IDX_Z = 2'd2;
  localparam logic [1:0] IDX_W = 2'd3;

  localparam logic signed [CAND_W-1:0] QONE = CAND_W'(1) <<< FRAC_BITS;
  localparam logic [CMP_W-1:0] QMAX_C = (CMP_W'(1) << (DATA_WIDTH - 1)) - CMP_W'(1);
  localparam logic [CMP_W-1:0] QMIN_MAG = CMP_W'(1) << (DATA_WIDTH - 1);
  localparam logic [DATA_WIDTH-1:0] QMAX_D = QMAX_C[DATA_WIDTH-1:0];
  localparam logic [DATA_WIDTH-1:0] QMIN_D = QMIN_MAG[DATA_WIDTH-1:0];
  localparam logic [DATA_WIDTH-1:0] QONE_SAT =
    (FRAC_BITS < DATA_WIDTH - 1) ? (DATA_WIDTH'(1) << FRAC_BITS) : QMAX_D;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] r11;
    logic signed [DATA_WIDTH-1:0] r12;
    logic signed [DATA_WIDTH-1:0] r13;
    logic signed [DATA_WIDTH-1:0] r21;
    logic signed [DATA_WIDTH-1:0] r22;
    logic signed [DATA_WIDTH-1:0] r23;
    logic signed [DATA_WIDTH-1:0] r31;
    logic signed [DATA_WIDTH-1:0] r32;
    logic signed [DATA_WIDTH-1:0] r33;
  } in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] quat_x;
    logic signed [DATA_WIDTH-1:0] quat_y;
    logic signed [DATA_WIDTH-1:0] quat_z;
    logic signed [DATA_WIDTH-1:0] quat_w;
    logic [1:0]                   largest_index;
    logic                         invalid;
  } out_t;

  // off-pivot lanes in ascending component order, as sign and magnitude
  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic [1:0]            idx;
    logic                  bad;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [N_W2-1:0]   n;
    side_t             side;
  } sq_t;

  typedef struct packed {
    logic [2:0][ROOT_W:0] rem;
    logic [2:0][QW-1:0]   acc;
    logic [ROOT_W-1:0]    v;
    logic [2:0]           neg;
    logic [1:0]           idx;
    logic                 bad;
  } dv_t;

  function automatic logic [DATA_WIDTH-1:0] sat_q(logic [CMP_W-1:0] mag, logic neg);
    logic [CMP_W-1:0] m2;
    m2 = ~mag + CMP_W'(1);
    if (!neg) begin
      sat_q = (mag > QMAX_C) ? QMAX_D : mag[DATA_WIDTH-1:0];
    end else begin
      sat_q = (mag > QMIN_MAG) ? QMIN_D : m2[DATA_WIDTH-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/rmq_front.sv -----
// Candidate forming, pivot selection and pair sums (two stages)
`default_nettype none
module rmq_front import rmq_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  input  wire in_t   in_data,
  output logic       out_valid,
  output logic [E_W-1:0] out_e,
  output side_t      out_side
);

  logic signed [CAND_W-1:0] cand_r [4];
  logic signed [CAND_W-1:0] cand_nxt [4];
  logic signed [SUM_W-1:0]  sxy_r, sxz_r, syz_r, dx_r, dy_r, dz_r;
  logic                     va_r, vb_r;
  logic [E_W-1:0]           e_r, e_nxt;
  side_t                    side_r, side_nxt;

  logic signed [CAND_W-1:0] a11, a22, a33;
  assign a11 = CAND_W'(in_data.r11);
  assign a22 = CAND_W'(in_data.r22);
  assign a33 = CAND_W'(in_data.r33);

  always_comb begin
    cand_nxt[0] = a11 - a22 - a33 + QONE;
    cand_nxt[1] = -a11 + a22 - a33 + QONE;
    cand_nxt[2] = -a11 - a22 + a33 + QONE;
    cand_nxt[3] = a11 + a22 + a33 + QONE;
  end

  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
    sxy_r  <= SUM_W'(in_data.r12) + SUM_W'(in_data.r21);
    sxz_r  <= SUM_W'(in_data.r31) + SUM_W'(in_data.r13);
    syz_r  <= SUM_W'(in_data.r23) + SUM_W'(in_data.r32);
    dx_r   <= SUM_W'(in_data.r32) - SUM_W'(in_data.r23);
    dy_r   <= SUM_W'(in_data.r13) - SUM_W'(in_data.r31);
    dz_r   <= SUM_W'(in_data.r21) - SUM_W'(in_data.r12);
    e_r    <= e_nxt;
    side_r <= side_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  logic signed [CAND_W-1:0] best;
  logic [1:0]               bidx;
  logic signed [SUM_W-1:0]  lane [3];
  logic [SUM_W-1:0]         su;

  always_comb begin
    best = cand_r[0];
    bidx = IDX_X;
    if (cand_r[1] > best) begin
      best = cand_r[1];
      bidx = IDX_Y;
    end
    if (cand_r[2] > best) begin
      best = cand_r[2];
      bidx = IDX_Z;
    end
    if (cand_r[3] > best) begin
      best = cand_r[3];
      bidx = IDX_W;
    end
    unique case (bidx)
      IDX_X: begin
        lane[0] = sxy_r; lane[1] = sxz_r; lane[2] = dx_r;
      end
      IDX_Y: begin
        lane[0] = sxy_r; lane[1] = syz_r; lane[2] = dy_r;
      end
      IDX_Z: begin
        lane[0] = sxz_r; lane[1] = syz_r; lane[2] = dz_r;
      end
      default: begin
        lane[0] = dx_r; lane[1] = dy_r; lane[2] = dz_r;
      end
    endcase
    side_nxt.idx = bidx;
    side_nxt.bad = best[CAND_W-1];
    e_nxt = best[CAND_W-1] ? '0 : best[E_W-1:0];
    for (int i = 0; i < 3; i++) begin
      su = lane[i];
      side_nxt.neg[i] = su[SUM_W-1];
      side_nxt.mag[i] = su[SUM_W-1] ? (~su + SUM_W'(1)) : su;
    end
  end

  assign out_valid = vb_r;
  assign out_e     = e_r;
  assign out_side  = side_r;

endmodule
`default_nettype wire

// ----- rtl/core/rmq_sqrt.sv -----
// Pipelined integer square root, one root bit per stage
`default_nettype none
module rmq_sqrt import rmq_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic [E_W-1:0] in_e,
  input  wire side_t          in_side,
  output logic                out_valid,
  output logic [ROOT_W-1:0]   out_v,
  output side_t               out_side
);

  sq_t  st_r  [ROOT_W];
  logic vld_r [ROOT_W];
  sq_t  src;

  always_comb begin
    src.rem  = '0;
    src.root = '0;
    src.n    = {{(N_W2 - E_W){1'b0}}, in_e} << (FRAC_BITS - 2);
    src.side = in_side;
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    sq_t              cur, st_nxt;
    logic             cur_v;
    logic [REM_W-1:0] trial, tval;
    if (k == 0) begin : g_first
      assign cur   = src;
      assign cur_v = in_valid;
    end else begin : g_next
      assign cur   = st_r[k-1];
      assign cur_v = vld_r[k-1];
    end
    always_comb begin
      trial = {cur.rem[REM_W-3:0], cur.n[N_W2-1 -: 2]};
      tval  = {cur.root, 2'b01};
      st_nxt      = cur;
      st_nxt.n    = cur.n << 2;
      if (trial >= tval) begin
        st_nxt.rem  = trial - tval;
        st_nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
      end else begin
        st_nxt.rem  = trial;
        st_nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      st_r[k] <= st_nxt;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= cur_v;
      end
    end
  end

  assign out_valid = vld_r[ROOT_W-1];
  assign out_v     = st_r[ROOT_W-1].root;
  assign out_side  = st_r[ROOT_W-1].side;

endmodule
`default_nettype wire

// ----- rtl/core/rmq_div.sv -----
// Three-lane pipelined rounded divider, one quotient bit per stage
`default_nettype none
module rmq_div import rmq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [ROOT_W-1:0] in_v,
  input  wire side_t             in_side,
  output logic                   out_valid,
  output dv_t                    out_dv
);

  dv_t  prep_r, prep_nxt;
  logic prep_v_r;
  dv_t  st_r  [QW];
  logic vld_r [QW];
  logic [DIVD_W-1:0] dvd [3];

  always_comb begin
    prep_nxt.v   = in_v;
    prep_nxt.neg = in_side.neg;
    prep_nxt.idx = in_side.idx;
    prep_nxt.bad = in_side.bad;
    for (int i = 0; i < 3; i++) begin
      dvd[i] = (DIVD_W'(in_side.mag[i]) << (FRAC_BITS - 2)) + DIVD_W'(in_v >> 1);
      prep_nxt.rem[i] = (ROOT_W + 1)'(dvd[i][DIVD_W-1:QW]);
      prep_nxt.acc[i] = dvd[i][QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prep_r <= prep_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_v_r <= 1'b0;
    end else begin
      prep_v_r <= in_valid;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    dv_t             cur, st_nxt;
    logic            cur_v;
    logic [ROOT_W:0] trial [3];
    logic            ge [3];
    if (k == 0) begin : g_first
      assign cur   = prep_r;
      assign cur_v = prep_v_r;
    end else begin : g_next
      assign cur   = st_r[k-1];
      assign cur_v = vld_r[k-1];
    end
    always_comb begin
      st_nxt = cur;
      for (int i = 0; i < 3; i++) begin
        trial[i] = {cur.rem[i][ROOT_W-1:0], cur.acc[i][QW-1]};
        ge[i]    = (trial[i] >= {1'b0, cur.v});
        st_nxt.rem[i] = ge[i] ? (trial[i] - {1'b0, cur.v}) : trial[i];
        st_nxt.acc[i] = {cur.acc[i][QW-2:0], ge[i]};
      end
    end
    always_ff @(posedge clk) begin
      st_r[k] <= st_nxt;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= cur_v;
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_dv    = st_r[QW-1];

endmodule
`default_nettype wire

// ----- rtl/core/rotation_matrix_to_quaternion_top.sv -----
// Rotation matrix to quaternion converter, top level
//
// Fully pipelined: one matrix beat can be started every clock (busy stays
// low) and each result appears on out_data with out_valid high for one
// cycle; values are in the default Q2.14 format. The depth is set by the
// square root pipeline (one root bit per stage) followed by the divider
// (one quotient bit per stage). The receiver cannot stall; results must
// be captured when shown.
`default_nettype none
module rotation_matrix_to_quaternion_top import rmq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_data,
  output logic      out_valid,
  output out_t      out_data
);

  logic              f_valid;
  logic [E_W-1:0]    f_e;
  side_t             f_side;
  logic              s_valid;
  logic [ROOT_W-1:0] s_v;
  side_t             s_side;
  logic              d_valid;
  dv_t               d_dv;

  out_t out_r, out_nxt;
  logic out_valid_r;

  assign busy = 1'b0;

  rmq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .in_data   (in_data),
    .out_valid (f_valid),
    .out_e     (f_e),
    .out_side  (f_side)
  );

  rmq_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_e      (f_e),
    .in_side   (f_side),
    .out_valid (s_valid),
    .out_v     (s_v),
    .out_side  (s_side)
  );

  rmq_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s_valid),
    .in_v      (s_v),
    .in_side   (s_side),
    .out_valid (d_valid),
    .out_dv    (d_dv)
  );

  logic [DATA_WIDTH-1:0] piv;
  logic [DATA_WIDTH-1:0] oth [3];

  always_comb begin
    piv = sat_q(CMP_W'(d_dv.v), 1'b0);
    for (int i = 0; i < 3; i++) begin
      oth[i] = (d_dv.v == '0) ? '0 : sat_q(CMP_W'(d_dv.acc[i]), d_dv.neg[i]);
    end
    out_nxt.largest_index = d_dv.idx;
    out_nxt.invalid       = d_dv.bad;
    unique case (d_dv.idx)
      IDX_X: begin
        out_nxt.quat_x = piv;    out_nxt.quat_y = oth[0];
        out_nxt.quat_z = oth[1]; out_nxt.quat_w = oth[2];
      end
      IDX_Y: begin
        out_nxt.quat_x = oth[0]; out_nxt.quat_y = piv;
        out_nxt.quat_z = oth[1]; out_nxt.quat_w = oth[2];
      end
      IDX_Z: begin
        out_nxt.quat_x = oth[0]; out_nxt.quat_y = oth[1];
        out_nxt.quat_z = piv;    out_nxt.quat_w = oth[2];
      end
      default: begin
        out_nxt.quat_x = oth[0]; out_nxt.quat_y = oth[1];
        out_nxt.quat_z = oth[2]; out_nxt.quat_w = piv;
      end
    endcase
    if (d_dv.bad) begin
      out_nxt.quat_x = '0;
      out_nxt.quat_y = '0;
      out_nxt.quat_z = '0;
      out_nxt.quat_w = QONE_SAT;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= d_valid;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ----- rtl/core/rmq_checker.sv -----
// Port-level checks for the rotation matrix to quaternion top level
`default_nettype none
`include "rotation_matrix_to_quaternion_top_defines.svh"
module rmq_checker import rmq_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire out_t out_data
);

  logic [DATA_WIDTH-1:0] pivot;

  always_comb begin
    unique case (out_data.largest_index)
      IDX_X:   pivot = out_data.quat_x;
      IDX_Y:   pivot = out_data.quat_y;
      IDX_Z:   pivot = out_data.quat_z;
      default: pivot = out_data.quat_w;
    endcase
  end

  `RMQ_ASSERT_RST(a_idle_after_reset, !rst_n |=> !out_valid)
  `RMQ_ASSERT(a_fixed_latency, (start && !busy) |-> ##LATENCY out_valid)
  `RMQ_ASSERT(a_never_invalid, out_valid |-> !out_data.invalid)
  `RMQ_ASSERT(a_pivot_positive, out_valid |-> !pivot[DATA_WIDTH-1])

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker u_rmq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
`default_nettype wire
